// ----- hw/rtl/ipadf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipadf_pkg: shared types and constants for the IPA deframer
// Frame and element phases, event codes, job and store-write records.
// ----------------------------------------------------------------------------
package ipadf_pkg;

	localparam int LEN_W = 6;

	localparam logic [7:0] PROTO_CCM      = 8'hFE;
	localparam logic [7:0] PROTO_OSMO     = 8'hEE;
	localparam logic [7:0] EXT_GSUP       = 8'h05;
	localparam logic [7:0] CCM_MSG_PING   = 8'h00;
	localparam logic [7:0] CCM_MSG_ID_REQ = 8'h04;
	localparam logic [7:0] CCM_MSG_ID_OK  = 8'h06;
	localparam logic [7:0] GSUP_SRI_ERR   = 8'h46;
	localparam logic [7:0] GSUP_SRI_RES   = 8'h47;
	localparam logic [7:0] IE_IMSI        = 8'h01;

	typedef enum logic [2:0] {
		PH_LEN_HI = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_SKIP   = 3'd2,
		PH_PROTO  = 3'd3,
		PH_EXT    = 3'd4,
		PH_BODY   = 3'd5
	} frame_phase_t;

	typedef enum logic [1:0] {
		EL_TAG = 2'd0,
		EL_LEN = 2'd1,
		EL_VAL = 2'd2
	} el_phase_t;

	typedef enum logic [2:0] {
		EV_PING  = 3'd0,
		EV_IDGET = 3'd1,
		EV_IDACK = 3'd2,
		EV_FAIL  = 3'd3,
		EV_IMSI  = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_NEXT = 2'd1,
		BK_CHK  = 2'd2
	} back_state_t;

	typedef struct packed {
		event_t             ev;
		logic [LEN_W-1:0]   len;
	} job_t;

	typedef struct packed {
		logic               we;
		logic [LEN_W-1:0]   addr;
		logic [7:0]         data;
	} store_wr_t;

endpackage

// ----- hw/rtl/ipadf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipadf_front: frame parser
// Splits the byte stream into IPA frames, walks GSUP elements, writes IMSI
// bytes into the store and posts one job per reporting frame.
// ----------------------------------------------------------------------------
module ipadf_front #(
	parameter int IMSI_BUF_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tuser,
	input  logic                 q_full,
	output logic                 q_push,
	output ipadf_pkg::job_t      q_job,
	output ipadf_pkg::store_wr_t store_wr,
	input  logic                 imsi_done
);

	ipadf_pkg::frame_phase_t      phase_q, phase_d;
	ipadf_pkg::el_phase_t         elph_q, elph_d;
	logic [15:0]                  flen_q, flen_d;
	logic [15:0]                  left_q, left_d;
	logic [15:0]                  left_dec;
	logic [7:0]                   proto_q, proto_d;
	logic [7:0]                   ext_q, ext_d;
	logic [7:0]                   mtype_q, mtype_d;
	logic [7:0]                   eltag_q, eltag_d;
	logic [7:0]                   elleft_q, elleft_d;
	logic [7:0]                   elleft_dec;
	logic                         stop_q, stop_d;
	logic                         copy_q, copy_d;
	logic [ipadf_pkg::LEN_W-1:0]  ilen_q, ilen_d;
	logic                         hold_q;
	logic                         accept;
	logic                         frame_end;
	logic                         first;
	logic [7:0]                   b;

	assign b        = s_tdata;
	assign s_tready = !q_full && !hold_q;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ipadf_pkg::PH_LEN_HI;
			elph_q   <= ipadf_pkg::EL_TAG;
			flen_q   <= '0;
			left_q   <= '0;
			proto_q  <= '0;
			ext_q    <= '0;
			mtype_q  <= '0;
			eltag_q  <= '0;
			elleft_q <= '0;
			stop_q   <= 1'b0;
			copy_q   <= 1'b0;
			ilen_q   <= '0;
			hold_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			elph_q   <= elph_d;
			flen_q   <= flen_d;
			left_q   <= left_d;
			proto_q  <= proto_d;
			ext_q    <= ext_d;
			mtype_q  <= mtype_d;
			eltag_q  <= eltag_d;
			elleft_q <= elleft_d;
			stop_q   <= stop_d;
			copy_q   <= copy_d;
			ilen_q   <= ilen_d;
			if (q_push && q_job.ev == ipadf_pkg::EV_IMSI) begin
				hold_q <= 1'b1;
			end else if (imsi_done) begin
				hold_q <= 1'b0;
			end
		end
	end

	assign left_dec   = left_q - 16'd1;
	assign elleft_dec = elleft_q - 8'd1;
	assign first      = (left_q == flen_q - 16'd1);

	always_comb begin
		phase_d   = phase_q;
		elph_d    = elph_q;
		flen_d    = flen_q;
		left_d    = left_q;
		proto_d   = proto_q;
		ext_d     = ext_q;
		mtype_d   = mtype_q;
		eltag_d   = eltag_q;
		elleft_d  = elleft_q;
		stop_d    = stop_q;
		copy_d    = copy_q;
		ilen_d    = ilen_q;
		frame_end = 1'b0;
		store_wr  = '0;
		q_push    = 1'b0;
		q_job     = '{ev: ipadf_pkg::EV_FAIL, len: '0};

		if (accept) begin
			if (s_tuser) begin
				phase_d  = ipadf_pkg::PH_LEN_HI;
				elph_d   = ipadf_pkg::EL_TAG;
				flen_d   = '0;
				left_d   = '0;
				proto_d  = '0;
				ext_d    = '0;
				mtype_d  = '0;
				eltag_d  = '0;
				elleft_d = '0;
				stop_d   = 1'b0;
				copy_d   = 1'b0;
				ilen_d   = '0;
			end else begin
				unique case (phase_q)
					ipadf_pkg::PH_LEN_HI: begin
						flen_d  = {b, 8'h00};
						phase_d = ipadf_pkg::PH_LEN_LO;
					end
					ipadf_pkg::PH_LEN_LO: begin
						flen_d  = {flen_q[15:8], b};
						phase_d = ({flen_q[15:8], b} == 16'd0) ? ipadf_pkg::PH_SKIP
							: ipadf_pkg::PH_PROTO;
					end
					ipadf_pkg::PH_SKIP: begin
						phase_d = ipadf_pkg::PH_LEN_HI;
					end
					ipadf_pkg::PH_PROTO: begin
						proto_d  = b;
						left_d   = flen_q;
						mtype_d  = '0;
						elph_d   = ipadf_pkg::EL_TAG;
						eltag_d  = '0;
						elleft_d = '0;
						stop_d   = 1'b0;
						copy_d   = 1'b0;
						ilen_d   = '0;
						phase_d  = ipadf_pkg::PH_EXT;
					end
					ipadf_pkg::PH_EXT: begin
						ext_d  = b;
						left_d = left_dec;
						if (left_dec == 16'd0) begin
							frame_end = 1'b1;
						end else begin
							phase_d = ipadf_pkg::PH_BODY;
						end
					end
					ipadf_pkg::PH_BODY: begin
						left_d = left_dec;
						if (proto_q == ipadf_pkg::PROTO_OSMO && ext_q == ipadf_pkg::EXT_GSUP)
						begin
							if (first) begin
								mtype_d = b;
							end else if (mtype_q == ipadf_pkg::GSUP_SRI_RES && !stop_q) begin
								unique case (elph_q)
									ipadf_pkg::EL_TAG: begin
										eltag_d = b;
										elph_d  = ipadf_pkg::EL_LEN;
									end
									ipadf_pkg::EL_LEN: begin
										elleft_d = b;
										copy_d   = 1'b0;
										if ({8'h00, b} > left_dec) begin
											stop_d = 1'b1;
										end else begin
											if (eltag_q == ipadf_pkg::IE_IMSI &&
												b < 8'(IMSI_BUF_BYTES)) begin
												copy_d = 1'b1;
												ilen_d = b[ipadf_pkg::LEN_W-1:0];
											end
											elph_d = (b == 8'd0) ? ipadf_pkg::EL_TAG
												: ipadf_pkg::EL_VAL;
										end
									end
									ipadf_pkg::EL_VAL: begin
										if (copy_q && elleft_q <= {2'b00, ilen_q}) begin
											store_wr.we   = 1'b1;
											store_wr.addr = ilen_q -
												elleft_q[ipadf_pkg::LEN_W-1:0];
											store_wr.data = b;
										end
										elleft_d = elleft_dec;
										if (elleft_dec == 8'd0) begin
											elph_d = ipadf_pkg::EL_TAG;
											copy_d = 1'b0;
										end
									end
									default: begin
										elph_d = ipadf_pkg::EL_TAG;
									end
								endcase
							end
						end
						if (left_dec == 16'd0) begin
							frame_end = 1'b1;
						end
					end
					default: begin
						phase_d = ipadf_pkg::PH_LEN_HI;
					end
				endcase

				if (frame_end) begin
					phase_d = ipadf_pkg::PH_LEN_HI;
					if (proto_q == ipadf_pkg::PROTO_CCM) begin
						q_push = 1'b1;
						priority if (ext_d == ipadf_pkg::CCM_MSG_PING) begin
							q_job.ev = ipadf_pkg::EV_PING;
						end else if (ext_d == ipadf_pkg::CCM_MSG_ID_REQ) begin
							q_job.ev = ipadf_pkg::EV_IDGET;
						end else if (ext_d == ipadf_pkg::CCM_MSG_ID_OK) begin
							q_job.ev = ipadf_pkg::EV_IDACK;
						end else begin
							q_push = 1'b0;
						end
					end else if (proto_q == ipadf_pkg::PROTO_OSMO &&
						ext_d == ipadf_pkg::EXT_GSUP && flen_q >= 16'd2) begin
						if (mtype_d == ipadf_pkg::GSUP_SRI_ERR) begin
							q_push   = 1'b1;
							q_job.ev = ipadf_pkg::EV_FAIL;
						end else if (mtype_d == ipadf_pkg::GSUP_SRI_RES) begin
							q_push    = 1'b1;
							q_job.ev  = ipadf_pkg::EV_IMSI;
							q_job.len = ilen_d;
						end
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/ipadf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipadf_queue: two-entry job queue
// Decouples the frame parser from the result sequencer.
// ----------------------------------------------------------------------------
module ipadf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ipadf_pkg::job_t push_job,
	input  logic            pop,
	output ipadf_pkg::job_t head,
	output logic            empty,
	output logic            full
);

	ipadf_pkg::job_t slot_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end

endmodule

// ----- hw/rtl/ipadf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipadf_back: result sequencer
// Holds the IMSI store, turns jobs into result items and drives the
// registered output stage.
// ----------------------------------------------------------------------------
module ipadf_back #(
	parameter int IMSI_BUF_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipadf_pkg::job_t      head,
	input  logic                 empty,
	output logic                 pop,
	input  ipadf_pkg::store_wr_t store_wr,
	output logic                 imsi_done,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic [2:0]           m_tuser,
	output logic                 m_tlast
);

	localparam int DEPTH  = IMSI_BUF_BYTES - 1;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [7:0]                   mem [DEPTH];
	logic [7:0]                   rdata_q;
	ipadf_pkg::back_state_t       state_q, state_d;
	logic [ipadf_pkg::LEN_W-1:0]  k_q, k_d;
	logic [ipadf_pkg::LEN_W-1:0]  len_q, len_d;
	logic [7:0]                   hold_q, hold_d;
	logic                         out_free;
	logic                         load;
	ipadf_pkg::event_t            ld_ev;
	logic [7:0]                   ld_byte;
	logic                         ld_last;
	logic                         out_valid_q;
	ipadf_pkg::event_t            out_ev_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;

	always_ff @(posedge clk) begin
		if (store_wr.we) begin
			mem[store_wr.addr[ADDR_W-1:0]] <= store_wr.data;
		end
		if (k_q < ipadf_pkg::LEN_W'(DEPTH)) begin
			rdata_q <= mem[k_q[ADDR_W-1:0]];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipadf_pkg::BK_IDLE;
			k_q     <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		len_d     = len_q;
		hold_d    = hold_q;
		pop       = 1'b0;
		imsi_done = 1'b0;
		load      = 1'b0;
		ld_ev     = ipadf_pkg::EV_FAIL;
		ld_byte   = 8'h00;
		ld_last   = 1'b1;
		unique case (state_q)
			ipadf_pkg::BK_IDLE: begin
				if (!empty) begin
					if (head.ev == ipadf_pkg::EV_IMSI) begin
						if (head.len == '0) begin
							if (out_free) begin
								pop       = 1'b1;
								load      = 1'b1;
								imsi_done = 1'b1;
							end
						end else begin
							pop     = 1'b1;
							len_d   = head.len;
							k_d     = '0;
							state_d = ipadf_pkg::BK_NEXT;
						end
					end else if (out_free) begin
						pop   = 1'b1;
						load  = 1'b1;
						ld_ev = head.ev;
					end
				end
			end
			ipadf_pkg::BK_NEXT: begin
				if (k_q == len_q) begin
					if (out_free) begin
						load      = 1'b1;
						ld_ev     = ipadf_pkg::EV_IMSI;
						ld_byte   = hold_q;
						imsi_done = 1'b1;
						state_d   = ipadf_pkg::BK_IDLE;
					end
				end else begin
					state_d = ipadf_pkg::BK_CHK;
				end
			end
			ipadf_pkg::BK_CHK: begin
				if (rdata_q == 8'h00) begin
					if (out_free) begin
						load      = 1'b1;
						imsi_done = 1'b1;
						state_d   = ipadf_pkg::BK_IDLE;
						if (k_q != '0) begin
							ld_ev   = ipadf_pkg::EV_IMSI;
							ld_byte = hold_q;
						end
					end
				end else if (k_q == '0) begin
					hold_d  = rdata_q;
					k_d     = k_q + 1'b1;
					state_d = ipadf_pkg::BK_NEXT;
				end else if (out_free) begin
					load    = 1'b1;
					ld_ev   = ipadf_pkg::EV_IMSI;
					ld_byte = hold_q;
					ld_last = 1'b0;
					hold_d  = rdata_q;
					k_d     = k_q + 1'b1;
					state_d = ipadf_pkg::BK_NEXT;
				end
			end
			default: begin
				state_d = ipadf_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ev_q   <= ld_ev;
			out_byte_q <= ld_byte;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- hw/rtl/ipa_deframer_gsup_imsi_extract.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipa_deframer_gsup_imsi_extract: IPA deframer with GSUP IMSI extraction
// Parses IPA frames from a byte stream, reports CCM ping, identity and SRI-SM
// error messages, and emits a GSUP SRI-SM result's IMSI one byte per item.
// ----------------------------------------------------------------------------
// Stream bytes are taken one per cycle while s_tready is high. A frame that
// reports a CCM message or an SRI-SM error posts one job into a two-entry
// queue and input keeps flowing while the queue has room. A frame that ends
// an SRI-SM result holds input off until its IMSI has been emitted: the IMSI
// store has one registered read port, so the sequencer reads each character
// in BK_NEXT and checks it in BK_CHK. The hold also covers any output stall
// and any jobs queued ahead. s_tuser high on an item resets the parser and
// discards any partial frame.
module ipa_deframer_gsup_imsi_extract #(
	parameter int IMSI_BUF_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] imsi_byte
	output logic [2:0] m_tuser,   // [2:0] event_res
	output logic       m_tlast
);

	ipadf_pkg::job_t      q_job;
	ipadf_pkg::job_t      q_head;
	ipadf_pkg::store_wr_t store_wr;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_empty;
	logic                 q_full;
	logic                 imsi_done;

	ipadf_front #(
		.IMSI_BUF_BYTES(IMSI_BUF_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job),
		.store_wr (store_wr),
		.imsi_done(imsi_done)
	);

	ipadf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_job),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	ipadf_back #(
		.IMSI_BUF_BYTES(IMSI_BUF_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.store_wr (store_wr),
		.imsi_done(imsi_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job queue overflow");

	a_imsi_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ipadf_pkg::EV_IMSI) |-> (m_tdata != 8'h00))
		else $error("zero IMSI character emitted");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ipadf_pkg::EV_IMSI) |-> (m_tlast && m_tdata == 8'h00))
		else $error("single-item event without last or with data");

	a_no_store_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(u_back.state_q != ipadf_pkg::BK_IDLE) |-> !store_wr.we)
		else $error("IMSI store written while being read");
`endif

endmodule

// ----- tb/ipa_deframer_gsup_imsi_extract_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipa_deframer_gsup_imsi_extract_tb: self-checking bench for the IPA deframer
// Feeds IPA frames (CCM, GSUP SRI-SM error and result, junk, link resets)
// byte by byte, predicts every event in a scoreboard and checks each output
// item in order, under random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module ipa_deframer_gsup_imsi_extract_tb;

	localparam int IMSI_MAX    = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		ipadf_pkg::event_t ev;
		logic [7:0]        chr;
		logic              eof;
	} gsup_event_t;

	class gsup_event_board;
		ipadf_pkg::frame_phase_t fph;
		logic [15:0]             flen;
		logic [15:0]             left;
		logic [7:0]              proto;
		logic [7:0]              ext;
		logic [7:0]              mtype;
		ipadf_pkg::el_phase_t    eph;
		logic [7:0]              etag;
		logic [7:0]              eleft;
		bit                      estop;
		bit                      copying;
		logic [7:0]              imsi [IMSI_MAX-1];
		int unsigned             ilen;
		gsup_event_t             due_events [$];
		int                      mismatches;
		int                      results_seen;

		function new();
			clear();
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void clear();
			fph = ipadf_pkg::PH_LEN_HI;
			flen = '0;
			left = '0;
			proto = '0;
			ext = '0;
			mtype = '0;
			eph = ipadf_pkg::EL_TAG;
			etag = '0;
			eleft = '0;
			estop = 1'b0;
			copying = 1'b0;
			ilen = 0;
			foreach (imsi[i]) imsi[i] = '0;
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		function void queue_event(ipadf_pkg::event_t ev, logic [7:0] chr, logic eof);
			due_events.push_back('{ev, chr, eof});
		endfunction

		// tag-length walk of an SRI-SM result body
		function void walk_ie(logic [7:0] b);
			int unsigned idx;
			if (estop)
				return;
			case (eph)
				ipadf_pkg::EL_TAG: begin
					etag = b;
					eph = ipadf_pkg::EL_LEN;
				end
				ipadf_pkg::EL_LEN: begin
					eleft = b;
					copying = 1'b0;
					if ({8'h00, b} > left) begin
						estop = 1'b1;
						return;
					end
					if (etag == ipadf_pkg::IE_IMSI && b < IMSI_MAX) begin
						copying = 1'b1;
						ilen = b;
					end
					eph = (b == 8'h00) ? ipadf_pkg::EL_TAG : ipadf_pkg::EL_VAL;
				end
				default: begin
					if (copying && eleft <= ilen) begin
						idx = ilen - eleft;
						if (idx < IMSI_MAX - 1)
							imsi[idx] = b;
					end
					eleft--;
					if (eleft == 8'h00) begin
						eph = ipadf_pkg::EL_TAG;
						copying = 1'b0;
					end
				end
			endcase
		endfunction

		function void close_frame();
			int n;
			n = 0;
			fph = ipadf_pkg::PH_LEN_HI;
			if (proto == ipadf_pkg::PROTO_CCM) begin
				case (ext)
					ipadf_pkg::CCM_MSG_PING:
						queue_event(ipadf_pkg::EV_PING, 8'h00, 1'b1);
					ipadf_pkg::CCM_MSG_ID_REQ:
						queue_event(ipadf_pkg::EV_IDGET, 8'h00, 1'b1);
					ipadf_pkg::CCM_MSG_ID_OK:
						queue_event(ipadf_pkg::EV_IDACK, 8'h00, 1'b1);
					default: ;
				endcase
				return;
			end
			if (proto != ipadf_pkg::PROTO_OSMO || ext != ipadf_pkg::EXT_GSUP || flen < 16'd2)
				return;
			if (mtype == ipadf_pkg::GSUP_SRI_ERR) begin
				queue_event(ipadf_pkg::EV_FAIL, 8'h00, 1'b1);
				return;
			end
			if (mtype != ipadf_pkg::GSUP_SRI_RES)
				return;
			while (n < ilen && n < IMSI_MAX - 1 && imsi[n] != 8'h00)
				n++;
			if (n == 0)
				queue_event(ipadf_pkg::EV_FAIL, 8'h00, 1'b1);
			for (int k = 0; k < n; k++)
				queue_event(ipadf_pkg::EV_IMSI, imsi[k], k == n - 1);
		endfunction

		// one accepted stream item
		function void consume_byte(bit link_reset, logic [7:0] b);
			bit first;
			if (link_reset) begin
				clear();
				return;
			end
			case (fph)
				ipadf_pkg::PH_LEN_HI: begin
					flen = {b, 8'h00};
					fph = ipadf_pkg::PH_LEN_LO;
				end
				ipadf_pkg::PH_LEN_LO: begin
					flen[7:0] = b;
					fph = (flen == 16'd0) ? ipadf_pkg::PH_SKIP : ipadf_pkg::PH_PROTO;
				end
				ipadf_pkg::PH_SKIP: fph = ipadf_pkg::PH_LEN_HI;
				ipadf_pkg::PH_PROTO: begin
					proto = b;
					left = flen;
					mtype = '0;
					eph = ipadf_pkg::EL_TAG;
					etag = '0;
					eleft = '0;
					estop = 1'b0;
					copying = 1'b0;
					ilen = 0;
					fph = ipadf_pkg::PH_EXT;
				end
				ipadf_pkg::PH_EXT: begin
					ext = b;
					left--;
					if (left == 16'd0)
						close_frame();
					else
						fph = ipadf_pkg::PH_BODY;
				end
				ipadf_pkg::PH_BODY: begin
					first = (left == flen - 16'd1);
					left--;
					if (proto == ipadf_pkg::PROTO_OSMO && ext == ipadf_pkg::EXT_GSUP) begin
						if (first)
							mtype = b;
						else if (mtype == ipadf_pkg::GSUP_SRI_RES)
							walk_ie(b);
					end
					if (left == 16'd0)
						close_frame();
				end
				default: fph = ipadf_pkg::PH_LEN_HI;
			endcase
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] result %0d: %s", $time, results_seen, what);
		endtask

		task check_event(logic [2:0] ev_bits, logic [7:0] chr, logic eof);
			gsup_event_t e;
			results_seen++;
			if (due_events.size() == 0) begin
				report($sformatf("unexpected item ev=%0d byte=%02h last=%0b",
					ev_bits, chr, eof));
				return;
			end
			e = due_events.pop_front();
			if (ev_bits !== e.ev)
				report($sformatf("event %0d, want %0d", ev_bits, e.ev));
			if (chr !== e.chr)
				report($sformatf("byte %02h, want %02h", chr, e.chr));
			if (eof !== e.eof)
				report($sformatf("last %0b, want %0b", eof, e.eof));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	gsup_event_board board = new();
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          rx_hold_len;
	int          items_sent;
	logic [7:0]  frame_q [$];

	ipa_deframer_gsup_imsi_extract #(
		.IMSI_BUF_BYTES(IMSI_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.consume_byte(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				board.check_event(m_tuser, m_tdata, m_tlast);
		end
	end

	// output side: random back-pressure, plus a long hold on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	task automatic send_item(bit link_reset, logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= link_reset;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_frame();
		logic [7:0] b;
		while (frame_q.size() != 0) begin
			b = frame_q.pop_front();
			send_item(1'b0, b);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// header, protocol, extension, then nbody bytes led by lead
	task automatic queue_frame(logic [7:0] proto, logic [7:0] ext, logic [7:0] lead,
			int nbody);
		logic [15:0] len;
		len = 16'(1 + nbody);
		frame_q.push_back(len[15:8]);
		frame_q.push_back(len[7:0]);
		frame_q.push_back(proto);
		frame_q.push_back(ext);
		if (nbody > 0)
			frame_q.push_back(lead);
		for (int k = 1; k < nbody; k++)
			frame_q.push_back(8'($urandom));
	endtask

	// SRI-SM result with random IEs; broken adds an overrun or a lone tag
	task automatic queue_sri_result(bit broken);
		logic [7:0]  body [$];
		logic [15:0] len;
		int          n_ie;
		int          ie_len;
		int          pick;
		int          k;
		int          r;
		n_ie = $urandom_range(1, 4);
		repeat (n_ie) begin
			if ($urandom_range(9) < 5) begin
				pick = $urandom_range(19);
				ie_len = (pick == 0) ? 0 : (pick == 1) ? IMSI_MAX - 1 :
					(pick == 2) ? $urandom_range(IMSI_MAX, IMSI_MAX + 8) :
					$urandom_range(1, 15);
				body.push_back(ipadf_pkg::IE_IMSI);
				body.push_back(8'(ie_len));
				repeat (ie_len) begin
					r = $urandom_range(29);
					body.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'($urandom) :
						8'h30 + 8'($urandom_range(9)));
				end
			end else begin
				ie_len = $urandom_range(0, 6);
				body.push_back(8'($urandom));
				body.push_back(8'(ie_len));
				repeat (ie_len) body.push_back(8'($urandom));
			end
		end
		if (broken) begin
			if ($urandom_range(1)) begin
				body.push_back(8'($urandom));
			end else begin
				k = $urandom_range(0, 6);
				body.push_back($urandom_range(1) ? ipadf_pkg::IE_IMSI : 8'($urandom));
				body.push_back(($urandom_range(3) == 0) ? 8'hFF :
					8'($urandom_range(k + 1, k + 8)));
				repeat (k) body.push_back(8'($urandom));
			end
		end
		len = 16'(2 + body.size());
		frame_q.push_back(len[15:8]);
		frame_q.push_back(len[7:0]);
		frame_q.push_back(ipadf_pkg::PROTO_OSMO);
		frame_q.push_back(ipadf_pkg::EXT_GSUP);
		frame_q.push_back(ipadf_pkg::GSUP_SRI_RES);
		while (body.size() != 0)
			frame_q.push_back(body.pop_front());
	endtask

	task automatic send_kind(int kind);
		logic [7:0] ccm_types [3];
		int         keep;
		ccm_types = '{ipadf_pkg::CCM_MSG_PING, ipadf_pkg::CCM_MSG_ID_REQ,
			ipadf_pkg::CCM_MSG_ID_OK};
		if (kind < 38) begin
			queue_sri_result(1'b0);
		end else if (kind < 48) begin
			queue_frame(ipadf_pkg::PROTO_CCM, ccm_types[$urandom_range(2)], 8'($urandom),
				$urandom_range(2) ? 0 : $urandom_range(1, 4));
		end else if (kind < 53) begin
			queue_frame(ipadf_pkg::PROTO_CCM, 8'($urandom), 8'($urandom),
				$urandom_range(0, 3));
		end else if (kind < 60) begin
			queue_frame(ipadf_pkg::PROTO_OSMO, ipadf_pkg::EXT_GSUP, ipadf_pkg::GSUP_SRI_ERR,
				$urandom_range(1, 4));
		end else if (kind < 66) begin
			case ($urandom_range(2))
				0: queue_frame(ipadf_pkg::PROTO_OSMO, ipadf_pkg::EXT_GSUP, 8'($urandom),
					$urandom_range(1, 5));
				1: queue_frame(ipadf_pkg::PROTO_OSMO, 8'($urandom), ipadf_pkg::GSUP_SRI_RES,
					$urandom_range(1, 5));
				default: queue_frame(8'($urandom), 8'($urandom), ipadf_pkg::GSUP_SRI_RES,
					$urandom_range(0, 5));
			endcase
		end else if (kind < 70) begin
			frame_q = '{8'h00, 8'h00, 8'($urandom)};
		end else if (kind < 73) begin
			queue_frame(ipadf_pkg::PROTO_OSMO, ipadf_pkg::EXT_GSUP, 8'h00, 0);
		end else if (kind < 82) begin
			queue_sri_result(1'b1);
		end else if (kind < 88) begin
			// frame cut short, sometimes with the largest length
			if ($urandom_range(1))
				frame_q = '{8'hFF, 8'hFF};
			else
				frame_q = '{8'h00, 8'($urandom_range(3, 200))};
			frame_q.push_back($urandom_range(1) ? ipadf_pkg::PROTO_OSMO
				: ipadf_pkg::PROTO_CCM);
			frame_q.push_back($urandom_range(1) ? ipadf_pkg::EXT_GSUP : 8'($urandom));
			repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
			keep = $urandom_range(1, frame_q.size());
			while (frame_q.size() > keep)
				void'(frame_q.pop_back());
		end else if (kind < 94) begin
			repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
		end
		send_frame();
		if (kind >= 82)
			send_item(1'b1, 8'($urandom));
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 1'b0;
		rx_hold_len = 0;
		items_sent = 0;
		tx_idle_pct = 11;
		rx_idle_pct = 51;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// partial header dropped by a link reset
		frame_q = '{8'h00, 8'h03};
		send_frame();
		send_item(1'b1, 8'hFF);
		queue_frame(ipadf_pkg::PROTO_CCM, ipadf_pkg::CCM_MSG_PING, 8'h00, 0);
		queue_frame(ipadf_pkg::PROTO_CCM, ipadf_pkg::CCM_MSG_ID_REQ, 8'h00, 0);
		queue_frame(ipadf_pkg::PROTO_CCM, ipadf_pkg::CCM_MSG_ID_OK, 8'h00, 0);
		// zero length: the byte after the header is skipped
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h00);
		frame_q.push_back(8'hFF);
		queue_frame(ipadf_pkg::PROTO_OSMO, ipadf_pkg::EXT_GSUP, ipadf_pkg::GSUP_SRI_ERR, 1);
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h05);
		frame_q.push_back(ipadf_pkg::PROTO_OSMO);
		frame_q.push_back(ipadf_pkg::EXT_GSUP);
		frame_q.push_back(ipadf_pkg::GSUP_SRI_RES);
		frame_q.push_back(ipadf_pkg::IE_IMSI);
		frame_q.push_back(8'h01);
		frame_q.push_back(8'h39);
		send_frame();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 51 : 0;
			rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 11 : 0;
			if (phase == 2) begin
				// long output stall while IMSI frames keep coming
				rx_hold_len = 400;
				repeat (3) send_kind(0);
			end
			while (items_sent < 130 + phase * 125)
				send_kind($urandom_range(99));
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- ipa_deframer_gsup_imsi_extract.f -----
hw/rtl/ipadf_pkg.sv
hw/rtl/ipadf_front.sv
hw/rtl/ipadf_queue.sv
hw/rtl/ipadf_back.sv
hw/rtl/ipa_deframer_gsup_imsi_extract.sv
tb/ipa_deframer_gsup_imsi_extract_tb.sv
